[rtl/rlfpe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlfpe_pkg
// Shared types and constants of the RGB LED frame PWM encoder: command codes,
// register indexes, sequencer states, reciprocal constants, memory request.
// ----------------------------------------------------------------------------
package rlfpe_pkg;

	// pixel word layout: green 23..16, red 15..8, blue 7..0
	localparam int PIX_W       = 24;
	localparam int BITS_PER_PX = 24;
	localparam int CHAN_W      = 8;
	localparam int ADDR_W      = 8;
	localparam int DUTY_W      = 16;
	localparam int MUL_W       = 16;
	localparam int PROD_W      = 32;

	// command codes
	localparam logic [2:0] MODE_SET   = 3'd0;
	localparam logic [2:0] MODE_GET   = 3'd1;
	localparam logic [2:0] MODE_OR    = 3'd2;
	localparam logic [2:0] MODE_XOR   = 3'd3;
	localparam logic [2:0] MODE_DIM   = 3'd4;
	localparam logic [2:0] MODE_CLEAR = 3'd5;

	// register indexes
	localparam logic [1:0] CFG_ONE_DUTY    = 2'd0;
	localparam logic [1:0] CFG_ZERO_DUTY   = 2'd1;
	localparam logic [1:0] CFG_LEAD_SLOTS  = 2'd2;
	localparam logic [1:0] CFG_LATCH_SLOTS = 2'd3;

	// register reset values
	localparam logic [15:0] ONE_DUTY_RST    = 16'd37;
	localparam logic [15:0] ZERO_DUTY_RST   = 16'd18;
	localparam logic [7:0]  LEAD_SLOTS_RST  = 8'd2;
	localparam logic [7:0]  LATCH_SLOTS_RST = 8'd40;

	// channel walk order of the dimming loop
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	// dimming percent scale
	localparam logic [7:0] PCT_FULL = 8'd100;

	// x/3 = (x*683)>>11, exact for x below 768 (bit slot / 8)
	localparam logic [15:0] DIV3_RECIP = 16'd683;
	localparam int          DIV3_SHIFT = 11;
	// y/100 = (y*5243)>>19, exact for y up to 255*100
	localparam logic [15:0] DIV100_RECIP = 16'd5243;
	localparam int          DIV100_SHIFT = 19;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CMD,
		ST_CDAT,
		ST_DMUL1,
		ST_DMUL2,
		ST_DSTO,
		ST_EPOS,
		ST_EDIV,
		ST_EADR,
		ST_EDAT,
		ST_DONE
	} rlfpe_state_t;

	// request to the pixel memory
	typedef struct packed {
		logic              we;
		logic              clr;
		logic [ADDR_W-1:0] waddr;
		logic [ADDR_W-1:0] raddr;
		logic [PIX_W-1:0]  wdata;
	} rlfpe_mem_req_t;

endpackage
`default_nettype wire

[rtl/rlfpe_mul_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlfpe_mul_unit
// Shared registered multiplier, used for the bit slot split and for dimming.
// ----------------------------------------------------------------------------
module rlfpe_mul_unit
	import rlfpe_pkg::*;
(
	input  wire logic              clk,
	input  wire logic [MUL_W-1:0]  a,
	input  wire logic [MUL_W-1:0]  b,
	output logic      [PROD_W-1:0] prod_q
);

	// one product per cycle, result ready the next cycle
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule
`default_nettype wire

[rtl/rlfpe_pixel_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlfpe_pixel_ram
// Pixel store: one write and one registered read port, with a valid bit per
// entry so that reset and clear-all blank the whole store at once.
// ----------------------------------------------------------------------------
module rlfpe_pixel_ram
	import rlfpe_pkg::*;
#(
	parameter int NUM_PIXELS = 64
)
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rlfpe_mem_req_t   req,
	output logic      [PIX_W-1:0] rdata
);

	localparam int AW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

	logic [PIX_W-1:0]      mem [NUM_PIXELS];
	logic [NUM_PIXELS-1:0] vld_q;
	logic [PIX_W-1:0]      rd_q;
	logic                  rd_vld_q;

	// data array
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[AW-1:0]] <= req.wdata;
		end
		rd_q <= mem[req.raddr[AW-1:0]];
	end

	// valid bits, an invalid entry reads as black
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.clr) begin
				vld_q <= '0;
			end else if (req.we) begin
				vld_q[req.waddr[AW-1:0]] <= 1'b1;
			end
			rd_vld_q <= vld_q[req.raddr[AW-1:0]];
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

[rtl/rgb_led_frame_pwm_encoder_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_led_frame_pwm_encoder_core
// Pixel store with set/get/or/xor/dim/clear commands and a PWM slot generator
// for the serial frame of an addressable RGB LED chain.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one command or emit request per beat, m_* channel
//   returns exactly one result beat for each. cfg_we/cfg_index/cfg_wdata
//   writes the duty and slot-count registers; the user must write them
//   only while the block is idle, which the block does not enforce. An
//   emit beat returns the next frame slot: slot_duty, with tlast on the
//   final latch slot of the frame.
// Steps per beat:
//   clear, unused mode, out-of-range index: command decode, then done
//   set, get, or, xor, dim above 100 percent: decode, then the data step
//   emit: position update, shared multiply for the bit split, memory read,
//   bit select; dim: two passes of the shared multiplier per channel
//   One beat is in work at a time; s_tready is high only when idle.
// Reset: pixel store reads black (valid bits cleared), frame position zero,
//   registers at their defaults. No clearing pass is needed.
// Stall: a finished result waits in the output register; the next beat can
//   be accepted, and its result waits until the held one is taken.
// ----------------------------------------------------------------------------
module rgb_led_frame_pwm_encoder_core
	import rlfpe_pkg::*;
#(
	parameter int NUM_PIXELS = 64
)
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command beats
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// pixel_index[7:0], red_in[15:8], green_in[23:16], blue_in[31:24],
	// dim_percent[39:32]
	input  wire logic [39:0] s_tdata,
	// mode[2:0], emit[3]
	input  wire logic [3:0]  s_tuser,
	// result beats
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// red_out[7:0], green_out[15:8], blue_out[23:16], slot_duty[39:24]
	output logic      [39:0] m_tdata,
	// status[0]
	output logic      [0:0]  m_tuser,
	output logic             m_tlast,
	// register writes
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	localparam int PIX_SLOTS = NUM_PIXELS * BITS_PER_PX;
	localparam int MAX_TOTAL = 2 * 255 + PIX_SLOTS;
	localparam int POS_W     = $clog2(MAX_TOTAL + 1);

	rlfpe_state_t state_q, state_d;

	// registers
	logic [DUTY_W-1:0] one_duty_q, zero_duty_q;
	logic [7:0]        lead_q, latch_q;

	// frame position
	logic [POS_W-1:0] slot_pos_q;

	// captured beat
	logic [2:0]        mode_q;
	logic              emit_q;
	logic [ADDR_W-1:0] idx_q;
	logic [CHAN_W-1:0] red_q, green_q, blue_q, pct_q;

	// working registers
	logic [POS_W-1:0] b_q;
	logic             in_pix_q;
	logic [4:0]       k_q;
	logic [PIX_W-1:0] work_q;
	logic [1:0]       ch_q;

	// result staging and output register
	logic              res_status_q;
	logic [PIX_W-1:0]  res_word_q;
	logic [DUTY_W-1:0] res_duty_q;
	logic              res_last_q;
	logic              m_tvalid_q;
	logic [39:0]       m_tdata_q;
	logic              m_tuser_q;
	logic              m_tlast_q;

	// shared units
	rlfpe_mem_req_t    mem_req;
	logic [PIX_W-1:0]  rdata;
	logic [MUL_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] prod_q;

	rlfpe_mul_unit u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	rlfpe_pixel_ram #(
		.NUM_PIXELS (NUM_PIXELS)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (rdata)
	);

	// handshakes
	logic s_fire, out_free;
	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// command decode
	logic in_range, dim_loop;
	assign in_range = ({1'b0, idx_q} < 9'(NUM_PIXELS));
	assign dim_loop = (mode_q == MODE_DIM) && (pct_q <= PCT_FULL);

	// frame position decode
	logic [POS_W-1:0] pix_end, total_m1;
	logic             pos_last, pos_in_pix;
	assign pix_end    = POS_W'(lead_q) + POS_W'(PIX_SLOTS);
	assign total_m1   = pix_end + POS_W'(latch_q) - POS_W'(1);
	assign pos_last   = (slot_pos_q >= total_m1);
	assign pos_in_pix = (slot_pos_q >= POS_W'(lead_q)) && (slot_pos_q < pix_end);

	// bit slot split: pixel = b/24, bit = b%24
	logic [POS_W-1:0]  x_div, q_ext, rem;
	logic [ADDR_W-1:0] q_pix;
	assign x_div = b_q >> 3;
	assign q_pix = prod_q[DIV3_SHIFT +: ADDR_W];
	assign q_ext = POS_W'(q_pix);
	assign rem   = x_div - (q_ext + (q_ext << 1));

	// slot bit from the fetched pixel
	logic slot_bit;
	assign slot_bit = rdata[5'(BITS_PER_PX - 1) - k_q];

	// command result word
	logic [PIX_W-1:0] given_word, cmd_word;
	logic             cmd_we;
	assign given_word = {green_q, red_q, blue_q};
	always_comb begin
		unique case (mode_q)
			MODE_SET: cmd_word = given_word;
			MODE_OR:  cmd_word = rdata | given_word;
			MODE_XOR: cmd_word = rdata ^ given_word;
			MODE_DIM: cmd_word = '0;
			default:  cmd_word = rdata;
		endcase
	end
	assign cmd_we = (mode_q != MODE_GET) && !dim_loop;

	// dimming channel select and replace
	logic [CHAN_W-1:0] dim_chan, dimmed;
	logic [PIX_W-1:0]  dim_word;
	assign dimmed = prod_q[DIV100_SHIFT +: CHAN_W];
	always_comb begin
		dim_word = work_q;
		unique case (ch_q)
			CH_RED: begin
				dim_chan        = work_q[15:8];
				dim_word[15:8]  = dimmed;
			end
			CH_GREEN: begin
				dim_chan        = work_q[23:16];
				dim_word[23:16] = dimmed;
			end
			default: begin
				dim_chan        = work_q[7:0];
				dim_word[7:0]   = dimmed;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					state_d = s_tuser[3] ? ST_EPOS : ST_CMD;
				end
			end
			ST_CMD: begin
				if ((mode_q >= MODE_CLEAR) || !in_range) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_CDAT;
				end
			end
			ST_CDAT:  state_d = dim_loop ? ST_DMUL1 : ST_DONE;
			ST_DMUL1: state_d = ST_DMUL2;
			ST_DMUL2: state_d = ST_DSTO;
			ST_DSTO:  state_d = (ch_q == CH_BLUE) ? ST_DONE : ST_DMUL1;
			ST_EPOS:  state_d = ST_EDIV;
			ST_EDIV:  state_d = ST_EADR;
			ST_EADR:  state_d = ST_EDAT;
			ST_EDAT:  state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// unit controls
	always_comb begin
		mem_req       = '0;
		mem_req.raddr = idx_q;
		mul_a         = '0;
		mul_b         = '0;
		unique case (state_q)
			ST_CMD: begin
				mem_req.clr = (mode_q == MODE_CLEAR);
			end
			ST_CDAT: begin
				mem_req.we    = cmd_we;
				mem_req.waddr = idx_q;
				mem_req.wdata = cmd_word;
			end
			ST_DMUL1: begin
				mul_a = MUL_W'(dim_chan);
				mul_b = MUL_W'(PCT_FULL - pct_q);
			end
			ST_DMUL2: begin
				mul_a = prod_q[MUL_W-1:0];
				mul_b = DIV100_RECIP;
			end
			ST_DSTO: begin
				mem_req.we    = (ch_q == CH_BLUE);
				mem_req.waddr = idx_q;
				mem_req.wdata = dim_word;
			end
			ST_EDIV: begin
				mul_a = MUL_W'(x_div);
				mul_b = DIV3_RECIP;
			end
			ST_EADR: begin
				mem_req.raddr = q_pix;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_pos_q  <= '0;
			ch_q        <= CH_RED;
			m_tvalid_q  <= 1'b0;
			one_duty_q  <= ONE_DUTY_RST;
			zero_duty_q <= ZERO_DUTY_RST;
			lead_q      <= LEAD_SLOTS_RST;
			latch_q     <= LATCH_SLOTS_RST;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ONE_DUTY:    one_duty_q  <= cfg_wdata;
					CFG_ZERO_DUTY:   zero_duty_q <= cfg_wdata;
					CFG_LEAD_SLOTS:  lead_q      <= cfg_wdata[7:0];
					CFG_LATCH_SLOTS: latch_q     <= cfg_wdata[7:0];
				endcase
			end
			if (state_q == ST_EPOS) begin
				slot_pos_q <= pos_last ? '0 : slot_pos_q + POS_W'(1);
			end
			if (state_q == ST_CDAT) begin
				ch_q <= CH_RED;
			end else if (state_q == ST_DSTO) begin
				ch_q <= ch_q + 2'd1;
			end
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_fire) begin
			idx_q   <= s_tdata[7:0];
			red_q   <= s_tdata[15:8];
			green_q <= s_tdata[23:16];
			blue_q  <= s_tdata[31:24];
			pct_q   <= s_tdata[39:32];
			mode_q  <= s_tuser[2:0];
			emit_q  <= s_tuser[3];
		end
		unique case (state_q)
			ST_CMD: begin
				res_status_q <= (mode_q < MODE_CLEAR) && !in_range;
				res_word_q   <= '0;
				res_duty_q   <= '0;
				res_last_q   <= 1'b0;
			end
			ST_CDAT: begin
				res_word_q <= cmd_word;
				work_q     <= rdata;
			end
			ST_DSTO: begin
				work_q     <= dim_word;
				res_word_q <= dim_word;
			end
			ST_EPOS: begin
				b_q          <= slot_pos_q - POS_W'(lead_q);
				in_pix_q     <= pos_in_pix;
				res_last_q   <= pos_last;
				res_status_q <= 1'b0;
				res_word_q   <= '0;
			end
			ST_EADR: begin
				k_q <= {rem[1:0], b_q[2:0]};
			end
			ST_EDAT: begin
				if (!in_pix_q) begin
					res_duty_q <= '0;
				end else if (slot_bit) begin
					res_duty_q <= one_duty_q;
				end else begin
					res_duty_q <= zero_duty_q;
				end
			end
			default: begin
			end
		endcase
		// load output register, emit beats carry no pixel
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {res_duty_q, res_word_q[7:0], res_word_q[23:16],
				res_word_q[15:8]};
			m_tuser_q <= res_status_q && !emit_q;
			m_tlast_q <= res_last_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;
	assign m_tlast    = m_tlast_q;

endmodule
`default_nettype wire
